FILE: rtl/text_terminal_scroll_engine_defines.svh
// ---------------------------------------------------------------------------
// Text terminal scroll engine: assertion macros
// Shared property shapes for the concurrent checks of the top level.
// ---------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCROLL_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_SCROLL_ENGINE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tts_pkg.sv
// ---------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the text terminal scroll engine modules.
// ---------------------------------------------------------------------------
package tts_pkg;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;
    localparam int FILL_W  = 8;

    // Request codes.
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } req_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_entry;
        logic [ROW_W-1:0]  cursor_row_now;
        logic [COL_W-1:0]  cursor_col_now;
        logic              did_scroll;
        logic              bad_address;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic locate;
        logic access;
    } ctrl_cmd_t;

endpackage

FILE: rtl/tts_ram.sv
// ---------------------------------------------------------------------------
// tts_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tts_ctrl.sv
// ---------------------------------------------------------------------------
// tts_ctrl
// Sequencer that walks each item through locate, access and result cycles.
// ---------------------------------------------------------------------------
module tts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output tts_pkg::ctrl_cmd_t cmd
);

    import tts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOCATE,
        S_ACCESS,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE, S_DONE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= S_LOCATE;
                        busy_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_LOCATE:
                begin
                    state_reg <= S_ACCESS;
                end
                S_ACCESS:
                begin
                    state_reg <= S_DONE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign cmd.capture = accept;
    assign cmd.locate  = (state_reg == S_LOCATE);
    assign cmd.access  = (state_reg == S_ACCESS);

endmodule

FILE: rtl/tts_datapath.sv
// ---------------------------------------------------------------------------
// tts_datapath
// Cursor, row offset, per-row fill counts and the screen memory.
// ---------------------------------------------------------------------------
module tts_datapath #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tts_pkg::ctrl_cmd_t               cmd,
    input  tts_pkg::req_t                    item,
    input  logic                             cfg_we,
    input  logic [tts_pkg::COLOR_W-1:0]      cfg_wdata,
    output tts_pkg::result_t                 result
);

    import tts_pkg::*;

    localparam int ROW_IW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELLS  = ROWS * COLUMNS;
    localparam int AW     = $clog2(CELLS);

    req_t               item_reg;
    logic [ROW_W-1:0]   cursor_row_reg;
    logic [COL_W-1:0]   cursor_col_reg;
    logic [ROW_IW-1:0]  top_reg;
    logic [COLOR_W-1:0] text_color_reg;
    logic [FILL_W-1:0]  fill_reg [ROWS];
    logic [COLOR_W-1:0] blank_color_reg [ROWS];
    logic [ROW_IW-1:0]  phys_row_reg;
    logic               bad_reg;
    logic               scroll_reg;
    logic               cell_valid_reg;
    logic [COLOR_W-1:0] cell_blank_reg;

    logic               is_read;
    logic [ROW_W-1:0]   log_row;
    logic [ROW_W:0]     row_sum;
    logic [ROW_IW-1:0]  phys_row_next;
    logic               bad_next;
    logic [COL_W-1:0]   access_col;
    logic [AW-1:0]      addr;
    logic               is_newline;
    logic [FILL_W-1:0]  col_inc;
    logic               row_end;
    logic               at_bottom;
    logic               cell_valid_next;
    logic               ram_we;
    logic               ram_re;
    logic [CELL_W-1:0]  ram_rdata;

    assign is_read = (item_reg.req_type == REQ_READ);

    // Logical row to physical row through the circular row offset.
    assign log_row = is_read ? item_reg.read_row : cursor_row_reg;
    assign row_sum = {1'b0, log_row} + (ROW_W + 1)'(top_reg);

    always_comb
    begin
        if (row_sum >= (ROW_W + 1)'(ROWS))
        begin
            phys_row_next = ROW_IW'(row_sum - (ROW_W + 1)'(ROWS));
        end
        else
        begin
            phys_row_next = ROW_IW'(row_sum);
        end
    end

    assign bad_next = is_read && ((32'(item_reg.read_row) >= ROWS) ||
                                  (32'(item_reg.read_col) >= COLUMNS));

    assign access_col = is_read ? item_reg.read_col : cursor_col_reg;
    assign addr = AW'(32'(phys_row_reg) * COLUMNS + 32'(access_col));

    assign is_newline = (item_reg.char_code == NEWLINE_CODE);
    assign col_inc    = {1'b0, cursor_col_reg} + FILL_W'(1);
    assign row_end    = is_newline || (col_inc == FILL_W'(COLUMNS));
    assign at_bottom  = (cursor_row_reg == ROW_W'(ROWS - 1));

    // Rows above the cursor hold written cells up to their fill count, the
    // cursor row up to the cursor column, and rows below hold only blanks.
    assign cell_valid_next =
        ((item_reg.read_row < cursor_row_reg) &&
         ({1'b0, item_reg.read_col} < fill_reg[phys_row_reg])) ||
        ((item_reg.read_row == cursor_row_reg) &&
         (item_reg.read_col < cursor_col_reg));

    assign ram_we = cmd.access && !is_read && !is_newline;
    assign ram_re = cmd.access && is_read && !bad_reg;

    tts_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata ({text_color_reg, item_reg.char_code}),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.locate)
        begin
            phys_row_reg <= phys_row_next;
            bad_reg      <= bad_next;
        end
        if (cmd.access)
        begin
            cell_valid_reg <= cell_valid_next;
            cell_blank_reg <= blank_color_reg[phys_row_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            top_reg        <= '0;
            text_color_reg <= RESET_COLOR;
            scroll_reg     <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                fill_reg[i]        <= '0;
                blank_color_reg[i] <= RESET_COLOR;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                text_color_reg <= cfg_wdata;
            end
            if (cmd.access)
            begin
                scroll_reg <= 1'b0;
                if (!is_read)
                begin
                    if (row_end)
                    begin
                        fill_reg[phys_row_reg] <= is_newline ? {1'b0, cursor_col_reg}
                                                             : FILL_W'(COLUMNS);
                        cursor_col_reg <= '0;
                        if (at_bottom)
                        begin
                            // The old top row becomes the new blank bottom row.
                            scroll_reg               <= 1'b1;
                            blank_color_reg[top_reg] <= text_color_reg;
                            if (top_reg == ROW_IW'(ROWS - 1))
                            begin
                                top_reg <= '0;
                            end
                            else
                            begin
                                top_reg <= top_reg + ROW_IW'(1);
                            end
                        end
                        else
                        begin
                            cursor_row_reg <= cursor_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        cursor_col_reg <= COL_W'(col_inc);
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (is_read && !bad_reg)
        begin
            result.cell_entry = cell_valid_reg ? ram_rdata : {cell_blank_reg, SPACE_CODE};
        end
        else
        begin
            result.cell_entry = '0;
        end
        result.cursor_row_now = cursor_row_reg;
        result.cursor_col_now = cursor_col_reg;
        result.did_scroll     = scroll_reg;
        result.bad_address    = is_read && bad_reg;
    end

endmodule

FILE: rtl/text_terminal_scroll_engine.sv
// ---------------------------------------------------------------------------
// text_terminal_scroll_engine
// Character terminal of ROWS by COLUMNS cells with cursor, wrap and scroll.
// ---------------------------------------------------------------------------
// Each item passes through three steps: mapping the logical row through the
// scroll offset, the single screen memory access, and the result step in
// which the result is shown on result with done high. A new item may be
// started in that result step, but the controller runs one item at a time
// through these three steps, so it takes no new item before the last one
// has finished. The receiver cannot stall: every result is present for exactly
// one cycle and must be taken then. Scrolling moves no data. The screen is a
// circular buffer of rows, and each row keeps a fill count and a blank color,
// so cells past the fill count read as spaces in the color the row had when
// it was last blanked. There is therefore no clearing pass after reset; the
// block takes items in the first cycle after reset is released. The text
// color register may be written at any time the block is idle and affects
// later writes and blanks.
// ---------------------------------------------------------------------------
`include "text_terminal_scroll_engine_defines.svh"

module text_terminal_scroll_engine #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tts_pkg::req_t               item,
    output logic                        done,
    output tts_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [tts_pkg::COLOR_W-1:0] cfg_wdata
);

    import tts_pkg::*;

    ctrl_cmd_t cmd;

    // The controller sequences each item; it only sees start.
    tts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the cursor, the row offset and the screen memory.
    tts_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // An accepted item keeps the block busy in the following cycle.
    `TTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")

    // The cursor reported with a result always lies on the screen.
    `TTS_ASSERT_NOW(a_cursor_on_screen, done,
        (32'(result.cursor_row_now) < ROWS) && (32'(result.cursor_col_now) < COLUMNS),
        "cursor off screen")

    // An off-screen read returns zero and never scrolls.
    `TTS_ASSERT_NOW(a_bad_read_clean, done && result.bad_address,
        (result.cell_entry == '0) && !result.did_scroll,
        "bad read returned data or scrolled")

    // A scroll leaves the cursor at column zero of the last row.
    `TTS_ASSERT_NOW(a_scroll_cursor, done && result.did_scroll,
        (32'(result.cursor_row_now) == ROWS - 1) && (result.cursor_col_now == '0),
        "scroll left cursor misplaced")

endmodule
